/* sv/c3cf_pkg.sv */
// Shared types and constants of the 3x3 clamp filter.
// Register map, reset values and the control structs between modules.
// No dependencies.
`default_nettype none

package c3cf_pkg;

    // Sample and port geometry
    localparam int SAMPLE_W     = 8;
    localparam int NUM_CH_PORTS = 4;
    localparam int PIXEL_MAX    = 255;

    // Configuration port geometry
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register field widths
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int NCH_W    = 3;
    localparam int KREG_W   = 24;

    // Largest frame height
    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [NCH_W-1:0]    NCH_RESET    = 3'd3;
    localparam logic [KREG_W-1:0]   KLEFT_RESET  = 24'hFFFFFF;
    localparam logic [KREG_W-1:0]   KMID_RESET   = 24'hFF08FF;
    localparam logic [KREG_W-1:0]   KRIGHT_RESET = 24'hFFFFFF;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH      = 3'd0,
        REG_IMAGE_HEIGHT     = 3'd1,
        REG_CHANNEL_COUNT    = 3'd2,
        REG_KERNEL_COL_LEFT  = 3'd3,
        REG_KERNEL_COL_MID   = 3'd4,
        REG_KERNEL_COL_RIGHT = 3'd5
    } reg_idx_t;

    // Position of the current stream item relative to the frame
    typedef struct packed {
        logic emit;    // item completes a result
        logic last;    // result is the last pixel of the frame
        logic left;    // result pixel sits on the left edge
        logic right;   // result pixel sits on the right edge
        logic top;     // result pixel sits on the top row
        logic bottom;  // result pixel sits on the bottom row
    } pos_t;

    // Edge masking seen by one window column cell
    typedef struct packed {
        logic col_off;     // whole column lies outside the frame
        logic top_off;     // upper tap lies outside the frame
        logic bottom_off;  // lower tap lies outside the frame
    } cell_mask_t;

endpackage

`default_nettype wire

/* sv/c3cf_line_store.sv */
// Two-row line store for the 3x3 clamp filter, one word per column.
// Single write port, single registered read port with write bypass.
// No package dependencies.
`default_nettype none

module c3cf_line_store #(
    parameter int  DEPTH = 1024,
    parameter int  DW    = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write, then read with bypass when both ports hit one column
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/c3cf_ctrl.sv */
// Stream position tracking for the 3x3 clamp filter.
// Column and row counters, line store addressing and edge flags.
// Depends on c3cf_pkg.
`default_nettype none

module c3cf_ctrl #(
    parameter int  MAX_WIDTH = 1024,
    localparam int AW        = $clog2(MAX_WIDTH),
    localparam int CW        = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          restart,
    input  wire logic [CW-1:0]                 w_eff,
    input  wire logic [c3cf_pkg::HEIGHT_W-1:0] h_eff,
    output logic      [AW-1:0]                 rd_addr,
    output logic      [AW-1:0]                 wr_addr,
    output c3cf_pkg::pos_t                     pos
);

    localparam int HW = c3cf_pkg::HEIGHT_W;

    logic [AW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;
    logic [AW-1:0] px, col_step;
    logic [HW-1:0] py, row_step, h_p1;
    logic [CW-1:0] col_inc;

    // Locate the result pixel that the current item completes
    always_comb
    begin
        h_p1 = h_eff + HW'(1);
        pos  = '0;
        if (col_reg != '0)
        begin
            pos.emit = (row_reg >= HW'(1)) && (row_reg <= h_eff);
            px       = col_reg - AW'(1);
            py       = row_reg - HW'(1);
        end
        else
        begin
            pos.emit = (row_reg >= HW'(2)) && (row_reg <= h_p1);
            pos.last = (row_reg == h_p1);
            px       = AW'(w_eff - CW'(1));
            py       = row_reg - HW'(2);
        end
        pos.left   = (px == '0);
        pos.right  = ((CW'(px) + CW'(1)) >= w_eff);
        pos.top    = (py == '0);
        pos.bottom = (({1'b0, py} + (HW + 1)'(1)) >= {1'b0, h_eff});
    end

    // Advance the counters, wrap at row and frame ends
    always_comb
    begin
        col_inc  = CW'(col_reg) + CW'(1);
        col_step = '0;
        row_step = '0;
        if (!pos.last)
        begin
            if (col_inc >= w_eff)
            begin
                col_step = '0;
                row_step = row_reg + HW'(1);
            end
            else
            begin
                col_step = AW'(col_inc);
                row_step = row_reg;
            end
            if (row_step > h_p1)
            begin
                row_step = '0;
            end
        end
        priority if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            col_next = col_step;
            row_next = row_step;
        end
        else
        begin
            col_next = col_reg;
            row_next = row_reg;
        end
    end

    // Hold the counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Read ahead at the column the next item will use
    assign rd_addr = col_next;
    assign wr_addr = col_reg;

endmodule

`default_nettype wire

/* sv/c3cf_cell.sv */
// One window column cell of the 3x3 clamp filter.
// Holds three taps per channel, shifts to its neighbor, forms a column sum.
// Depends on c3cf_pkg.
`default_nettype none

module c3cf_cell #(
    parameter int  MAX_CHANNELS = 4,
    parameter int  COEF_BITS    = 8,
    localparam int COL_W        = 3 * MAX_CHANNELS * c3cf_pkg::SAMPLE_W,
    localparam int PSUM_W       = COEF_BITS + c3cf_pkg::SAMPLE_W + 2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             clear,
    input  wire logic                             shift,
    input  wire logic                             load,
    input  wire logic [COL_W-1:0]                 col_in,
    output logic      [COL_W-1:0]                 col_out,
    input  wire logic [3*COEF_BITS-1:0]           coef,
    input  c3cf_pkg::cell_mask_t                  mask,
    output logic      [MAX_CHANNELS*PSUM_W-1:0]   psum
);

    localparam int SW     = c3cf_pkg::SAMPLE_W;
    localparam int PROD_W = COEF_BITS + SW;

    logic [COL_W-1:0]               col_reg;
    logic [MAX_CHANNELS*PSUM_W-1:0] psum_reg, psum_next;

    // Hold the column taps, take the neighbor's column on each item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (clear)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    // Weight the three taps of every channel and add the ones in frame
    always_comb
    begin
        logic signed [PSUM_W-1:0] acc;
        logic signed [PROD_W-1:0] tap, wgt, prod;
        psum_next = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            acc = '0;
            for (int dy = 0; dy < 3; dy++)
            begin
                tap  = PROD_W'({1'b0, col_reg[(dy*MAX_CHANNELS + c)*SW +: SW]});
                wgt  = PROD_W'($signed(coef[dy*COEF_BITS +: COEF_BITS]));
                prod = tap * wgt;
                if (!((dy == 0) && mask.top_off) && !((dy == 2) && mask.bottom_off))
                begin
                    acc = acc + PSUM_W'(prod);
                end
            end
            if (mask.col_off)
            begin
                acc = '0;
            end
            psum_next[c*PSUM_W +: PSUM_W] = acc;
        end
    end

    // Register the column sums
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            psum_reg <= psum_next;
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

`default_nettype wire

/* sv/conv3x3_clamp_filter.sv */
// 3x3 zero-padded convolution with clamping over a raster pixel stream.
// Top level: register file, line store, column cell chain, output stage.
// Depends on c3cf_pkg, c3cf_ctrl, c3cf_line_store, c3cf_cell.
//
// Usage:
//  - Pixels enter in raster order on the in_valid/in_ready channel, up to
//    four 8-bit samples each; flush marks an item that carries zeros.
//    After each frame send width+1 flush items to drain the last results.
//  - The result for pixel (x,y) is produced by the item one row and one
//    pixel later and leaves on out_valid/out_ready; frame_end flags the
//    last pixel of the frame.
//  - The completing item is registered into the window, then into the
//    column sums and then the output register, which drives out_valid.
//  - Throughput: one item per cycle while in_ready is high, set by the
//    single-port column read of the line store and the three-cell window chain.
//  - Configure over the APB port while the stream is idle; writing the
//    width or height restarts the frame.
//  - Reset loads the register defaults and clears counters and window;
//    the line store is not cleared, rows outside the frame are masked.
//  - A stalled receiver fills the three stages, then in_ready drops.
`default_nettype none

module conv3x3_clamp_filter #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4,
    parameter int COEF_BITS    = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [c3cf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [c3cf_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [c3cf_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      sample_ch0,
    input  wire logic [7:0]                      sample_ch1,
    input  wire logic [7:0]                      sample_ch2,
    input  wire logic [7:0]                      sample_ch3,
    input  wire logic                            flush,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [7:0]                      result_ch0,
    output logic      [7:0]                      result_ch1,
    output logic      [7:0]                      result_ch2,
    output logic      [7:0]                      result_ch3,
    output logic                                 frame_end
);

    localparam int SW     = c3cf_pkg::SAMPLE_W;
    localparam int NP     = c3cf_pkg::NUM_CH_PORTS;
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int CHW    = MAX_CHANNELS * SW;
    localparam int COL_W  = 3 * CHW;
    localparam int KW     = 3 * COEF_BITS;
    localparam int PSUM_W = COEF_BITS + SW + 2;
    localparam int SUM_W  = PSUM_W + 2;
    localparam int HW     = c3cf_pkg::HEIGHT_W;
    localparam int NW     = c3cf_pkg::NCH_W;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(c3cf_pkg::PIXEL_MAX);

    // Configuration registers
    logic [c3cf_pkg::WIDTH_W-1:0] width_reg;
    logic [HW-1:0]                height_reg;
    logic [NW-1:0]                nch_reg;
    logic [c3cf_pkg::KREG_W-1:0]  kleft_reg, kmid_reg, kright_reg;

    logic              cfg_wr;
    logic              restart;
    c3cf_pkg::reg_idx_t cfg_idx;

    logic [CW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [NW-1:0] nch_eff;

    // Pipeline control
    logic en0, en1, en2, accept;
    logic v0_reg, v1_reg, v2_reg;
    logic last1_reg, fe_reg;
    c3cf_pkg::pos_t pos, pos_hold_reg;

    // Data path
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [2*CHW-1:0] ls_rd, ls_wr;
    logic [CHW-1:0]   s_vec;
    logic [7:0]       in_samp [NP];
    logic [COL_W-1:0] col_new, col1, col2, col0_unused;
    logic [MAX_CHANNELS*PSUM_W-1:0] psum0, psum1, psum2;
    c3cf_pkg::cell_mask_t mask0, mask1, mask2;
    logic [7:0] res_reg [NP];
    logic [7:0] res_next [NP];

    assign cfg_idx = c3cf_pkg::reg_idx_t'(paddr[c3cf_pkg::APB_ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign restart = cfg_wr && ((cfg_idx == c3cf_pkg::REG_IMAGE_WIDTH) ||
                                (cfg_idx == c3cf_pkg::REG_IMAGE_HEIGHT));

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= c3cf_pkg::WIDTH_RESET;
            height_reg <= c3cf_pkg::HEIGHT_RESET;
            nch_reg    <= c3cf_pkg::NCH_RESET;
            kleft_reg  <= c3cf_pkg::KLEFT_RESET;
            kmid_reg   <= c3cf_pkg::KMID_RESET;
            kright_reg <= c3cf_pkg::KRIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                c3cf_pkg::REG_IMAGE_WIDTH:      width_reg  <= pwdata[c3cf_pkg::WIDTH_W-1:0];
                c3cf_pkg::REG_IMAGE_HEIGHT:     height_reg <= pwdata[HW-1:0];
                c3cf_pkg::REG_CHANNEL_COUNT:    nch_reg    <= pwdata[NW-1:0];
                c3cf_pkg::REG_KERNEL_COL_LEFT:  kleft_reg  <= pwdata[c3cf_pkg::KREG_W-1:0];
                c3cf_pkg::REG_KERNEL_COL_MID:   kmid_reg   <= pwdata[c3cf_pkg::KREG_W-1:0];
                c3cf_pkg::REG_KERNEL_COL_RIGHT: kright_reg <= pwdata[c3cf_pkg::KREG_W-1:0];
                default:                        ;
            endcase
        end
    end

    // Return register contents
    always_comb
    begin
        unique case (cfg_idx)
            c3cf_pkg::REG_IMAGE_WIDTH:      prdata = 32'(width_reg);
            c3cf_pkg::REG_IMAGE_HEIGHT:     prdata = 32'(height_reg);
            c3cf_pkg::REG_CHANNEL_COUNT:    prdata = 32'(nch_reg);
            c3cf_pkg::REG_KERNEL_COL_LEFT:  prdata = 32'(kleft_reg);
            c3cf_pkg::REG_KERNEL_COL_MID:   prdata = 32'(kmid_reg);
            c3cf_pkg::REG_KERNEL_COL_RIGHT: prdata = 32'(kright_reg);
            default:                        prdata = '0;
        endcase
    end

    // Clamp geometry and channel count into their usable ranges
    always_comb
    begin
        priority if (width_reg == '0)
            w_eff = CW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_reg);

        priority if (height_reg == '0)
            h_eff = HW'(1);
        else if (height_reg > c3cf_pkg::HEIGHT_LIMIT)
            h_eff = c3cf_pkg::HEIGHT_LIMIT;
        else
            h_eff = height_reg;

        priority if (nch_reg == '0)
            nch_eff = NW'(1);
        else if (32'(nch_reg) > 32'(MAX_CHANNELS))
            nch_eff = NW'(MAX_CHANNELS);
        else
            nch_eff = nch_reg;
    end

    // Stage enables: a stage moves when the next one is empty or moving
    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign in_ready = en0;
    assign accept   = in_valid && in_ready;

    c3cf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .restart (restart),
        .w_eff   (w_eff),
        .h_eff   (h_eff),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .pos     (pos)
    );

    // Gather incoming samples, zero for flush items
    assign in_samp[0] = sample_ch0;
    assign in_samp[1] = sample_ch1;
    assign in_samp[2] = sample_ch2;
    assign in_samp[3] = sample_ch3;

    always_comb
    begin
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            s_vec[c*SW +: SW] = flush ? '0 : in_samp[c];
        end
    end

    // Lower row moves up, new samples become the lower row
    assign ls_wr   = {ls_rd[CHW-1:0], s_vec};
    assign col_new = {s_vec, ls_rd[CHW-1:0], ls_rd[2*CHW-1:CHW]};

    c3cf_line_store #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * CHW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (ls_wr),
        .rd_addr (rd_addr),
        .rd_data (ls_rd)
    );

    // Hold edge flags with the window while its result waits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_hold_reg <= pos;
        end
    end

    assign mask0 = '{col_off: pos_hold_reg.left,  top_off: pos_hold_reg.top,
                     bottom_off: pos_hold_reg.bottom};
    assign mask1 = '{col_off: 1'b0,               top_off: pos_hold_reg.top,
                     bottom_off: pos_hold_reg.bottom};
    assign mask2 = '{col_off: pos_hold_reg.right, top_off: pos_hold_reg.top,
                     bottom_off: pos_hold_reg.bottom};

    // Window chain: right cell takes the new column, columns move left
    c3cf_cell #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .COEF_BITS    (COEF_BITS)
    ) u_cell_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (restart),
        .shift   (accept),
        .load    (en1),
        .col_in  (col_new),
        .col_out (col2),
        .coef    (KW'(kright_reg)),
        .mask    (mask2),
        .psum    (psum2)
    );

    c3cf_cell #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .COEF_BITS    (COEF_BITS)
    ) u_cell_mid (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (restart),
        .shift   (accept),
        .load    (en1),
        .col_in  (col2),
        .col_out (col1),
        .coef    (KW'(kmid_reg)),
        .mask    (mask1),
        .psum    (psum1)
    );

    c3cf_cell #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .COEF_BITS    (COEF_BITS)
    ) u_cell_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (restart),
        .shift   (accept),
        .load    (en1),
        .col_in  (col1),
        .col_out (col0_unused),
        .coef    (KW'(kleft_reg)),
        .mask    (mask0),
        .psum    (psum0)
    );

    // Add the column sums, clamp, drop unused channels
    for (genvar c = 0; c < NP; c++)
    begin : g_out
        if (c < MAX_CHANNELS)
        begin : g_used
            logic signed [SUM_W-1:0] total;
            always_comb
            begin
                total = SUM_W'($signed(psum0[c*PSUM_W +: PSUM_W]))
                      + SUM_W'($signed(psum1[c*PSUM_W +: PSUM_W]))
                      + SUM_W'($signed(psum2[c*PSUM_W +: PSUM_W]));
                priority if (NW'(c) >= nch_eff)
                    res_next[c] = '0;
                else if (total[SUM_W-1])
                    res_next[c] = '0;
                else if (total > SUM_MAX)
                    res_next[c] = 8'(c3cf_pkg::PIXEL_MAX);
                else
                    res_next[c] = total[7:0];
            end
        end
        else
        begin : g_unused
            assign res_next[c] = '0;
        end
    end

    // Advance valid flags through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                v0_reg <= pos.emit;
            else if (en1)
                v0_reg <= 1'b0;
            if (en1)
                v1_reg <= v0_reg;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    // Move frame flag and results along with the valid flags
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            last1_reg <= pos_hold_reg.last;
        end
        if (en2)
        begin
            fe_reg <= last1_reg;
            for (int c = 0; c < NP; c++)
            begin
                res_reg[c] <= res_next[c];
            end
        end
    end

    assign out_valid  = v2_reg;
    assign frame_end  = fe_reg;
    assign result_ch0 = res_reg[0];
    assign result_ch1 = res_reg[1];
    assign result_ch2 = res_reg[2];
    assign result_ch3 = res_reg[3];

endmodule

`default_nettype wire

/* tb/conv3x3_result_checker.sv */
// Result checker for the 3x3 clamp filter: watches the configuration port
// and both item channels, predicts each filtered pixel and compares it.
// Depends on c3cf_pkg for register indexes, widths and reset values.
`timescale 1ns / 100ps

module conv3x3_result_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [c3cf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [c3cf_pkg::APB_DATA_W-1:0] pwdata,
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire logic [7:0]                      sample_ch0,
    input  wire logic [7:0]                      sample_ch1,
    input  wire logic [7:0]                      sample_ch2,
    input  wire logic [7:0]                      sample_ch3,
    input  wire logic                            flush,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire logic [7:0]                      result_ch0,
    input  wire logic [7:0]                      result_ch1,
    input  wire logic [7:0]                      result_ch2,
    input  wire logic [7:0]                      result_ch3,
    input  wire logic                            frame_end,
    output int                                   fail_count,
    output int                                   pending_count
);
    import c3cf_pkg::*;

    localparam int LINE_MAX   = 1024;
    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [NUM_CH_PORTS-1:0][7:0] chan;
        logic                         last_px;
    } filtered_px_t;

    // Shadow copy of the register file
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic [NCH_W-1:0]    cfg_chans;
    logic [KREG_W-1:0]   cfg_kleft;
    logic [KREG_W-1:0]   cfg_kmid;
    logic [KREG_W-1:0]   cfg_kright;

    // Two previous rows per column, the 3x3 window [column][row], stream position
    logic [7:0] upper_rows [LINE_MAX][NUM_CH_PORTS];
    logic [7:0] lower_rows [LINE_MAX][NUM_CH_PORTS];
    logic [7:0] window_px  [3][3][NUM_CH_PORTS];
    int         col_pos;
    int         row_pos;

    filtered_px_t pending_pixels[$];
    int           mismatches = 0;

    // Rows outside the frame are masked, so any start value will do
    initial
    begin
        for (int x = 0; x < LINE_MAX; x++)
            for (int c = 0; c < NUM_CH_PORTS; c++)
            begin
                upper_rows[x][c] = '0;
                lower_rows[x][c] = '0;
            end
    end

    function automatic int clamp_range(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Signed coefficient of row offset dy (0 = upper) from one kernel column
    function automatic int tap(logic [KREG_W-1:0] k, int dy);
        logic signed [7:0] b;
        b = k[dy*8 +: 8];
        return int'(b);
    endfunction

    task automatic restart_frame();
        col_pos = 0;
        row_pos = 0;
        for (int dx = 0; dx < 3; dx++)
            for (int dy = 0; dy < 3; dy++)
                for (int c = 0; c < NUM_CH_PORTS; c++)
                    window_px[dx][dy][c] = '0;
    endtask

    task automatic apply_write(input logic [APB_ADDR_W-1:0] addr,
                               input logic [APB_DATA_W-1:0] data);
        case (addr[APB_ADDR_W-1:2])
            REG_IMAGE_WIDTH:
            begin
                cfg_width = data[WIDTH_W-1:0];
                restart_frame();
            end
            REG_IMAGE_HEIGHT:
            begin
                cfg_height = data[HEIGHT_W-1:0];
                restart_frame();
            end
            REG_CHANNEL_COUNT:    cfg_chans  = data[NCH_W-1:0];
            REG_KERNEL_COL_LEFT:  cfg_kleft  = data[KREG_W-1:0];
            REG_KERNEL_COL_MID:   cfg_kmid   = data[KREG_W-1:0];
            REG_KERNEL_COL_RIGHT: cfg_kright = data[KREG_W-1:0];
            default: ;
        endcase
    endtask

    // Shift one item into the window and queue the pixel it completes, if any
    task automatic filter_accepted_pixel(input logic [NUM_CH_PORTS-1:0][7:0] smp,
                                         input logic fl);
        int                w;
        int                h;
        int                nch;
        int                col;
        int                row;
        int                px;
        int                py;
        int                sum;
        bit                emit;
        bit                last;
        logic [7:0]        s [NUM_CH_PORTS];
        logic [KREG_W-1:0] kcol [3];
        filtered_px_t      res;

        w    = clamp_range(cfg_width, 1, LINE_MAX);
        h    = clamp_range(cfg_height, 1, HEIGHT_LIMIT);
        nch  = clamp_range(cfg_chans, 1, NUM_CH_PORTS);
        col  = (col_pos >= w) ? 0 : col_pos;
        row  = row_pos;
        emit = 0;
        last = 0;
        px   = 0;
        py   = 0;

        // Advance the window and rotate the line store at this column
        for (int c = 0; c < NUM_CH_PORTS; c++)
        begin
            s[c] = fl ? 8'h00 : smp[c];
            for (int dy = 0; dy < 3; dy++)
            begin
                window_px[0][dy][c] = window_px[1][dy][c];
                window_px[1][dy][c] = window_px[2][dy][c];
            end
            window_px[2][0][c] = upper_rows[col][c];
            window_px[2][1][c] = lower_rows[col][c];
            window_px[2][2][c] = s[c];
            upper_rows[col][c] = lower_rows[col][c];
            lower_rows[col][c] = s[c];
        end

        // Locate the pixel this item completes
        if (col >= 1)
        begin
            if (row >= 1 && row <= h)
            begin
                emit = 1;
                px   = col - 1;
                py   = row - 1;
            end
        end
        else if (row >= 2 && row <= h + 1)
        begin
            emit = 1;
            px   = w - 1;
            py   = row - 2;
            last = (row == h + 1);
        end

        if (emit)
        begin
            kcol[0] = cfg_kleft;
            kcol[1] = cfg_kmid;
            kcol[2] = cfg_kright;
            for (int c = 0; c < NUM_CH_PORTS; c++)
            begin
                sum = 0;
                if (c < nch)
                begin
                    for (int dx = 0; dx < 3; dx++)
                    begin
                        if ((dx == 0 && px == 0) || (dx == 2 && px + 1 >= w))
                            continue;
                        for (int dy = 0; dy < 3; dy++)
                        begin
                            if ((dy == 0 && py == 0) || (dy == 2 && py + 1 >= h))
                                continue;
                            sum += int'(window_px[dx][dy][c]) * tap(kcol[dx], dy);
                        end
                    end
                    sum = clamp_range(sum, 0, PIXEL_MAX);
                end
                res.chan[c] = sum[7:0];
            end
            res.last_px = last;
            pending_pixels.push_back(res);
        end

        // Step the stream position
        if (last)
        begin
            col = 0;
            row = 0;
        end
        else
        begin
            col++;
            if (col >= w)
            begin
                col = 0;
                row++;
            end
            if (row > h + 1)
                row = 0;
        end
        col_pos = col;
        row_pos = row;
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        if (mismatches < REPORT_CAP)
            $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
    endtask

    // Compare one delivered item against the oldest prediction
    task automatic check_result();
        filtered_px_t                 want;
        logic [NUM_CH_PORTS-1:0][7:0] got;

        got = {result_ch3, result_ch2, result_ch1, result_ch0};
        if (pending_pixels.size() == 0)
        begin
            if (mismatches < REPORT_CAP)
                $error("result item with no pixel predicted");
            mismatches++;
            return;
        end
        want = pending_pixels.pop_front();
        for (int c = 0; c < NUM_CH_PORTS; c++)
            if (got[c] !== want.chan[c])
                note_mismatch($sformatf("result_ch%0d", c), want.chan[c], got[c]);
        if (frame_end !== want.last_px)
            note_mismatch("frame_end", want.last_px, frame_end);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width  = WIDTH_RESET;
            cfg_height = HEIGHT_RESET;
            cfg_chans  = NCH_RESET;
            cfg_kleft  = KLEFT_RESET;
            cfg_kmid   = KMID_RESET;
            cfg_kright = KRIGHT_RESET;
            restart_frame();
            pending_pixels.delete();
            pending_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                apply_write(paddr, pwdata);
            if (in_valid && in_ready)
                filter_accepted_pixel({sample_ch3, sample_ch2, sample_ch1, sample_ch0}, flush);
            if (out_valid && out_ready)
                check_result();
            pending_count <= pending_pixels.size();
        end
        fail_count <= mismatches;
    end

endmodule

/* tb/conv3x3_clamp_filter_test.sv */
// Top of the 3x3 clamp filter bench: clock, reset, register writes, pixel
// stream with bursts and gaps, receiver stalls, watchdog and verdict.
// Depends on c3cf_pkg, conv3x3_clamp_filter and conv3x3_result_checker.
`timescale 1ns / 100ps

module conv3x3_clamp_filter_test;
    import c3cf_pkg::*;

    localparam int ITEM_TARGET   = 1200;
    localparam int SETTLE_CYCLES = 10;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int LINE_MAX      = 1024;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [7:0]            sample_ch0 = '0;
    logic [7:0]            sample_ch1 = '0;
    logic [7:0]            sample_ch2 = '0;
    logic [7:0]            sample_ch3 = '0;
    logic                  flush      = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [7:0]            result_ch0;
    logic [7:0]            result_ch1;
    logic [7:0]            result_ch2;
    logic [7:0]            result_ch3;
    logic                  frame_end;

    int fail_count;
    int pending_count;
    int burst_left    = 0;
    int items_sent    = 0;
    bit count_items   = 0;
    int hold_requests = 0;
    int idle_cycles   = 0;

    logic [WIDTH_W-1:0]  cur_width  = WIDTH_RESET;
    logic [HEIGHT_W-1:0] cur_height = HEIGHT_RESET;

    always #4 clk = ~clk;

    conv3x3_clamp_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_ch0 (sample_ch0),
        .sample_ch1 (sample_ch1),
        .sample_ch2 (sample_ch2),
        .sample_ch3 (sample_ch3),
        .flush      (flush),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_ch0 (result_ch0),
        .result_ch1 (result_ch1),
        .result_ch2 (result_ch2),
        .result_ch3 (result_ch3),
        .frame_end  (frame_end)
    );

    conv3x3_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_ch0    (sample_ch0),
        .sample_ch1    (sample_ch1),
        .sample_ch2    (sample_ch2),
        .sample_ch3    (sample_ch3),
        .flush         (flush),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_ch0    (result_ch0),
        .result_ch1    (result_ch1),
        .result_ch2    (result_ch2),
        .result_ch3    (result_ch3),
        .frame_end     (frame_end),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic int eff_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [3:0][7:0] rand_pixel();
        logic [3:0][7:0] p;
        for (int c = 0; c < 4; c++)
            p[c] = rand_sample();
        return p;
    endfunction

    function automatic logic [KREG_W-1:0] rand_kernel();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h7F7F7F;
            3:       return 24'h808080;
            default: return 24'($urandom());
        endcase
    endfunction

    // One register write: setup phase, access phase until pready, then idle
    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        case (idx)
            REG_IMAGE_WIDTH:  cur_width  = value[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: cur_height = value[HEIGHT_W-1:0];
            default: ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item; open a new burst after a random gap when the old one ends
    task automatic push_item(input logic [3:0][7:0] smp, input logic fl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        sample_ch0 <= smp[0];
        sample_ch1 <= smp[1];
        sample_ch2 <= smp[2];
        sample_ch3 <= smp[3];
        flush      <= fl;
        do @(posedge clk); while (!in_ready);
        if (count_items)
            items_sent++;
    endtask

    // Drop valid, drain every predicted pixel, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Frame of the current geometry plus its flush tail; a broken one stops
    // at a random item or runs a few items into the next frame
    task automatic push_frame(input bit broken);
        int w;
        int h;
        int n_px;
        int n_all;
        int stop;
        w     = eff_dim(cur_width, LINE_MAX);
        h     = eff_dim(cur_height, HEIGHT_LIMIT);
        n_px  = w * h;
        n_all = n_px + w + 1;
        stop  = broken ? $urandom_range(1, n_all + 3) : n_all;
        for (int i = 0; i < stop; i++)
        begin
            if (i < n_px || i >= n_all)
                push_item(rand_pixel(), $urandom_range(0, 19) == 0);
            else
                push_item(rand_pixel(), $urandom_range(0, 7) != 0);
        end
    endtask

    // Receiver: long hold-off on request, otherwise a changing stall pattern
    initial
    begin : rx_side
        rx_mode_e mode;
        int       mode_left;
        int       tick;
        int       hold_left;
        int       hold_served;
        mode        = RX_OPEN;
        mode_left   = 0;
        tick        = 0;
        hold_left   = 0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 7) != 0);
                    default:   out_ready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stim
        logic [3:0][7:0] px;
        int              phase_no;
        int              frames;
        bit              special;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Small frame, all four channels, coefficient extremes
        apb_write(REG_IMAGE_WIDTH, 4);
        apb_write(REG_IMAGE_HEIGHT, 3);
        apb_write(REG_CHANNEL_COUNT, 4);
        apb_write(REG_KERNEL_COL_LEFT, 24'h017F80);
        apb_write(REG_KERNEL_COL_MID, 24'hFF08FF);
        apb_write(REG_KERNEL_COL_RIGHT, 24'h80007F);
        hold_requests++;
        for (int i = 0; i < 12; i++)
        begin
            case (i % 4)
                0:       px = {4{8'hFF}};
                1:       px = '0;
                2:       px = {8'h01, 8'h80, 8'h00, 8'hFF};
                default: px = {8'hFF, 8'h00, 8'hFF, 8'h7F};
            endcase
            // one flush item inside the frame
            push_item(px, i == 6);
        end
        // tail: flush items carry junk samples, one plain pixel among them
        for (int i = 0; i < 5; i++)
            push_item({4{8'hFF}}, i != 2);

        // Partial frame, then restart it by a geometry write
        for (int i = 0; i < 3; i++)
            push_item(rand_pixel(), 1'b0);
        wait_idle();
        apb_write(REG_IMAGE_WIDTH, 1);
        apb_write(REG_IMAGE_HEIGHT, 1);
        apb_write(REG_CHANNEL_COUNT, 1);
        push_item({4{8'hFF}}, 1'b0);
        push_item('0, 1'b1);
        push_item('0, 1'b1);

        // Random phases; the first few use extreme and out-of-range geometry
        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            special     = (phase_no < 4);
            count_items = !special;
            if (special)
            begin
                case (phase_no)
                    0:
                    begin
                        apb_write(REG_IMAGE_WIDTH, 0);
                        apb_write(REG_IMAGE_HEIGHT, 0);
                        apb_write(REG_CHANNEL_COUNT, 0);
                    end
                    1:
                    begin
                        apb_write(REG_IMAGE_WIDTH, 2047);
                        apb_write(REG_IMAGE_HEIGHT, 1);
                        apb_write(REG_CHANNEL_COUNT, 7);
                    end
                    2:
                    begin
                        apb_write(REG_IMAGE_WIDTH, 1024);
                        apb_write(REG_IMAGE_HEIGHT, 2);
                        apb_write(REG_CHANNEL_COUNT, 4);
                        hold_requests++;
                    end
                    default:
                    begin
                        apb_write(REG_IMAGE_WIDTH, 1);
                        apb_write(REG_IMAGE_HEIGHT, 8191);
                        apb_write(REG_CHANNEL_COUNT, 5);
                    end
                endcase
                apb_write(REG_KERNEL_COL_LEFT, rand_kernel());
                apb_write(REG_KERNEL_COL_MID, rand_kernel());
                apb_write(REG_KERNEL_COL_RIGHT, rand_kernel());
            end
            else
            begin
                if ($urandom_range(0, 1))
                    apb_write(REG_IMAGE_WIDTH, $urandom_range(1, 12));
                if ($urandom_range(0, 1))
                    apb_write(REG_IMAGE_HEIGHT, $urandom_range(1, 6));
                if ($urandom_range(0, 1))
                    apb_write(REG_CHANNEL_COUNT, $urandom_range(0, 7));
                if ($urandom_range(0, 1))
                    apb_write(REG_KERNEL_COL_LEFT, rand_kernel());
                if ($urandom_range(0, 1))
                    apb_write(REG_KERNEL_COL_MID, rand_kernel());
                if ($urandom_range(0, 1))
                    apb_write(REG_KERNEL_COL_RIGHT, rand_kernel());
            end
            frames = special ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
                push_frame(!special && $urandom_range(0, 6) == 0);
            phase_no++;
        end

        wait_idle();
        if (fail_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/c3cf_pkg.sv
sv/c3cf_line_store.sv
sv/c3cf_ctrl.sv
sv/c3cf_cell.sv
sv/conv3x3_clamp_filter.sv
tb/conv3x3_result_checker.sv
tb/conv3x3_clamp_filter_test.sv
